// ===== rtl/core/fpba_pkg.sv =====
// shared types, codes and defaults of the fit-policy block allocator
package fpba_pkg;

  // fixed field widths
  localparam int FIELD_W   = 20;
  localparam int STATUS_W  = 2;
  localparam int POLICY_W  = 2;
  localparam int CFG_IDX_W = 2;

  // parameter defaults
  localparam int FREE_ENTRIES_DEF = 16;
  localparam int USED_ENTRIES_DEF = 16;
  localparam int ADDR_BITS_DEF    = 20;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // search policies (the unused code behaves as first fit)
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd2;

  localparam logic [FIELD_W-1:0] HEAP_LIMIT_RST = 20'hFFFFF;

  // per-entry decisions of the scan unit
  typedef struct packed {
    logic fit_take;    // free entry becomes the current allocation candidate
    logic match_take;  // allocated entry matches the address being freed
    logic spare_take;  // first empty free slot
    logic slot_take;   // first empty allocated slot
  } pick_t;

endpackage

// ===== rtl/core/fit_policy_block_allocator.sv =====
// top level of the fit-policy block allocator: sequencer, tables and heap top
//
// Usage: a request (in_op, in_req_size, in_block_address) transfers at a rising
// edge where start is high and busy is low. busy stays high while the request
// is worked on; start is ignored meanwhile. Each request gives exactly one
// result, shown for one cycle with out_valid high; the receiver cannot stall it.
// An allocate searches the free table by first, best or worst fit, splits the
// chosen block or takes space from the heap top; a free moves a matching
// allocated entry into the free table.
// One request at a time: it passes the scan, drain and finish states and its
// result is registered. The scan reads one entry of each table ram per cycle
// through one compare unit. The configuration port writes fit_policy,
// heap_base (which also reloads the heap top) and heap_limit; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset (synchronous, rst_n low) empties both tables, loads the register
// reset values and sets the heap top to the reset heap base.
module fit_policy_block_allocator #(
  parameter int FREE_ENTRIES = fpba_pkg::FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = fpba_pkg::USED_ENTRIES_DEF,
  parameter int ADDR_BITS    = fpba_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [fpba_pkg::FIELD_W-1:0]   in_req_size,
  input  logic [fpba_pkg::FIELD_W-1:0]   in_block_address,
  // result channel
  output logic                           out_valid,
  output logic [fpba_pkg::FIELD_W-1:0]   out_grant_address,
  output logic [fpba_pkg::FIELD_W-1:0]   out_granted_size,
  output logic [fpba_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_from_free_list,
  // configuration port
  input  logic                           cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpba_pkg::FIELD_W-1:0]   cfg_data
);

  localparam int FW      = fpba_pkg::FIELD_W;
  localparam int SCAN_N  = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int CNT_W   = $clog2(SCAN_N);
  localparam int CNT_W1  = CNT_W + 1;
  localparam int FIDX_W  = $clog2(FREE_ENTRIES);
  localparam int UIDX_W  = $clog2(USED_ENTRIES);
  localparam int ENTRY_W = ADDR_BITS + FW;
  localparam int SUM_W   = ((ADDR_BITS > FW) ? ADDR_BITS : FW) + 1;

  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SCAN_N - 1);
  localparam logic [CNT_W1-1:0] FREE_LIM = CNT_W1'(FREE_ENTRIES);
  localparam logic [CNT_W1-1:0] USED_LIM = CNT_W1'(USED_ENTRIES);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]               rd_idx_r, rd_idx_nxt;

  // configuration and heap state
  logic [fpba_pkg::POLICY_W-1:0]  policy_r, policy_nxt;
  logic [FW-1:0]                  heap_base_r, heap_base_nxt;
  logic [FW-1:0]                  heap_limit_r, heap_limit_nxt;
  logic [ADDR_BITS-1:0]           heap_top_r, heap_top_nxt;
  logic [FREE_ENTRIES-1:0]        free_valid_r, free_valid_nxt;
  logic [USED_ENTRIES-1:0]        used_valid_r, used_valid_nxt;

  // request being worked on
  logic                           op_r, op_nxt;
  logic [FW-1:0]                  req_r, req_nxt;
  logic [ADDR_BITS-1:0]           baddr_r, baddr_nxt;

  // scan trackers
  logic                           pick_found_r, pick_found_nxt;
  logic [CNT_W-1:0]               pick_idx_r, pick_idx_nxt;
  logic [ADDR_BITS-1:0]           pick_addr_r, pick_addr_nxt;
  logic [FW-1:0]                  pick_size_r, pick_size_nxt;
  logic                           spare_found_r, spare_found_nxt;
  logic [CNT_W-1:0]               spare_idx_r, spare_idx_nxt;
  logic                           slot_found_r, slot_found_nxt;
  logic [CNT_W-1:0]               slot_idx_r, slot_idx_nxt;

  // result registers
  logic                           out_valid_r, out_valid_nxt;
  logic [FW-1:0]                  out_addr_r, out_addr_nxt;
  logic [FW-1:0]                  out_size_r, out_size_nxt;
  logic [fpba_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                           out_ff_r, out_ff_nxt;

  // ram ports
  logic                           free_we, used_we;
  logic [FIDX_W-1:0]              free_waddr;
  logic [UIDX_W-1:0]              used_waddr;
  logic [ENTRY_W-1:0]             free_wdata, used_wdata;
  logic [ENTRY_W-1:0]             free_rdata, used_rdata;

  // scan datapath
  logic                           accept;
  logic [FIDX_W-1:0]              rd_fidx;
  logic [UIDX_W-1:0]              rd_uidx;
  logic                           free_in, used_in;
  logic                           free_v, used_v;
  logic [ADDR_BITS-1:0]           free_addr_rd, used_addr_rd;
  logic [FW-1:0]                  free_size_rd, used_size_rd;
  fpba_pkg::pick_t                take;

  // finishing arithmetic
  logic [SUM_W-1:0]               new_top;
  logic                           heap_over;
  logic                           split;
  logic [ADDR_BITS-1:0]           rem_addr;
  logic [FW-1:0]                  rem_size;
  logic [FW-1:0]                  grant;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // table rams: {address, size} per entry
  fpba_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (cnt_r[FIDX_W-1:0]),
    .rdata (free_rdata)
  );

  fpba_ram #(.WIDTH(ENTRY_W), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (cnt_r[UIDX_W-1:0]),
    .rdata (used_rdata)
  );

  // entry read back in the cycle after its index was issued
  assign rd_fidx      = rd_idx_r[FIDX_W-1:0];
  assign rd_uidx      = rd_idx_r[UIDX_W-1:0];
  assign free_in      = rd_vld_r && ({1'b0, rd_idx_r} < FREE_LIM);
  assign used_in      = rd_vld_r && ({1'b0, rd_idx_r} < USED_LIM);
  assign free_v       = free_in && free_valid_r[rd_fidx];
  assign used_v       = used_in && used_valid_r[rd_uidx];
  assign free_addr_rd = free_rdata[ENTRY_W-1:FW];
  assign free_size_rd = free_rdata[FW-1:0];
  assign used_addr_rd = used_rdata[ENTRY_W-1:FW];
  assign used_size_rd = used_rdata[FW-1:0];

  fpba_pick #(.ADDR_BITS(ADDR_BITS)) u_pick (
    .op          (op_r),
    .policy      (policy_r),
    .req_size    (req_r),
    .block_addr  (baddr_r),
    .free_in     (free_in),
    .free_v      (free_v),
    .free_size   (free_size_rd),
    .used_in     (used_in),
    .used_v      (used_v),
    .used_addr   (used_addr_rd),
    .pick_found  (pick_found_r),
    .best_size   (pick_size_r),
    .spare_found (spare_found_r),
    .slot_found  (slot_found_r),
    .take        (take)
  );

  // heap growth and block split arithmetic
  assign new_top   = SUM_W'(heap_top_r) + SUM_W'(req_r);
  assign heap_over = new_top > SUM_W'(heap_limit_r);
  assign split     = (pick_size_r > req_r) && spare_found_r;
  assign rem_addr  = pick_addr_r + ADDR_BITS'(req_r);
  assign rem_size  = pick_size_r - req_r;
  assign grant     = split ? req_r : pick_size_r;

  // sequencer and table update
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = (state_r == S_SCAN);
    rd_idx_nxt      = cnt_r;
    policy_nxt      = policy_r;
    heap_base_nxt   = heap_base_r;
    heap_limit_nxt  = heap_limit_r;
    heap_top_nxt    = heap_top_r;
    free_valid_nxt  = free_valid_r;
    used_valid_nxt  = used_valid_r;
    op_nxt          = op_r;
    req_nxt         = req_r;
    baddr_nxt       = baddr_r;
    pick_found_nxt  = pick_found_r;
    pick_idx_nxt    = pick_idx_r;
    pick_addr_nxt   = pick_addr_r;
    pick_size_nxt   = pick_size_r;
    spare_found_nxt = spare_found_r;
    spare_idx_nxt   = spare_idx_r;
    slot_found_nxt  = slot_found_r;
    slot_idx_nxt    = slot_idx_r;
    out_valid_nxt   = 1'b0;
    out_addr_nxt    = out_addr_r;
    out_size_nxt    = out_size_r;
    out_status_nxt  = out_status_r;
    out_ff_nxt      = out_ff_r;
    free_we         = 1'b0;
    free_waddr      = spare_idx_r[FIDX_W-1:0];
    free_wdata      = {rem_addr, rem_size};
    used_we         = 1'b0;
    used_waddr      = slot_idx_r[UIDX_W-1:0];
    used_wdata      = {pick_addr_r, grant};

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::CFG_FIT_POLICY: policy_nxt = cfg_data[fpba_pkg::POLICY_W-1:0];
        fpba_pkg::CFG_HEAP_BASE: begin
          heap_base_nxt = cfg_data;
          heap_top_nxt  = ADDR_BITS'(cfg_data);
        end
        fpba_pkg::CFG_HEAP_LIMIT: heap_limit_nxt = cfg_data;
        default: ;
      endcase
    end

    // trackers follow the entry under the scan unit
    if (take.fit_take) begin
      pick_found_nxt = 1'b1;
      pick_idx_nxt   = rd_idx_r;
      pick_addr_nxt  = free_addr_rd;
      pick_size_nxt  = free_size_rd;
    end
    if (take.match_take) begin
      pick_found_nxt = 1'b1;
      pick_idx_nxt   = rd_idx_r;
      pick_addr_nxt  = used_addr_rd;
      pick_size_nxt  = used_size_rd;
    end
    if (take.spare_take) begin
      spare_found_nxt = 1'b1;
      spare_idx_nxt   = rd_idx_r;
    end
    if (take.slot_take) begin
      slot_found_nxt = 1'b1;
      slot_idx_nxt   = rd_idx_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt          = in_op;
          req_nxt         = in_req_size;
          baddr_nxt       = ADDR_BITS'(in_block_address);
          pick_found_nxt  = 1'b0;
          spare_found_nxt = 1'b0;
          slot_found_nxt  = 1'b0;
          cnt_nxt         = '0;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = '0;
        out_size_nxt   = '0;
        out_ff_nxt     = 1'b0;
        out_status_nxt = fpba_pkg::ST_OK;
        if (op_r == fpba_pkg::OP_ALLOC) begin
          if ((req_r == '0) || !slot_found_r) begin
            out_status_nxt = fpba_pkg::ST_NO_SPACE;
          end else if (pick_found_r) begin
            // split the chosen free block, remainder to the spare slot
            if (split) begin
              free_we                        = 1'b1;
              free_valid_nxt[spare_idx_r[FIDX_W-1:0]] = 1'b1;
            end
            free_valid_nxt[pick_idx_r[FIDX_W-1:0]] = 1'b0;
            used_we                              = 1'b1;
            used_valid_nxt[slot_idx_r[UIDX_W-1:0]] = 1'b1;
            out_addr_nxt = FW'(pick_addr_r);
            out_size_nxt = grant;
            out_ff_nxt   = 1'b1;
          end else if (heap_over) begin
            out_status_nxt = fpba_pkg::ST_NO_SPACE;
          end else begin
            // grow the heap top
            used_we                              = 1'b1;
            used_wdata                           = {heap_top_r, req_r};
            used_valid_nxt[slot_idx_r[UIDX_W-1:0]] = 1'b1;
            heap_top_nxt                         = ADDR_BITS'(new_top);
            out_addr_nxt                         = FW'(heap_top_r);
            out_size_nxt                         = req_r;
          end
        end else begin
          if (!pick_found_r) begin
            out_status_nxt = fpba_pkg::ST_NOT_FOUND;
          end else if (!spare_found_r) begin
            out_status_nxt = fpba_pkg::ST_NO_SPACE;
          end else begin
            // move the allocated entry into the free table
            free_we                                 = 1'b1;
            free_wdata                              = {pick_addr_r, pick_size_r};
            free_valid_nxt[spare_idx_r[FIDX_W-1:0]] = 1'b1;
            used_valid_nxt[pick_idx_r[UIDX_W-1:0]]  = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_vld_r      <= 1'b0;
      policy_r      <= fpba_pkg::POL_FIRST;
      heap_base_r   <= '0;
      heap_limit_r  <= fpba_pkg::HEAP_LIMIT_RST;
      heap_top_r    <= '0;
      free_valid_r  <= '0;
      used_valid_r  <= '0;
      pick_found_r  <= 1'b0;
      spare_found_r <= 1'b0;
      slot_found_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rd_vld_r      <= rd_vld_nxt;
      policy_r      <= policy_nxt;
      heap_base_r   <= heap_base_nxt;
      heap_limit_r  <= heap_limit_nxt;
      heap_top_r    <= heap_top_nxt;
      free_valid_r  <= free_valid_nxt;
      used_valid_r  <= used_valid_nxt;
      pick_found_r  <= pick_found_nxt;
      spare_found_r <= spare_found_nxt;
      slot_found_r  <= slot_found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    baddr_r      <= baddr_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_addr_r  <= pick_addr_nxt;
    pick_size_r  <= pick_size_nxt;
    spare_idx_r  <= spare_idx_nxt;
    slot_idx_r   <= slot_idx_nxt;
    out_addr_r   <= out_addr_nxt;
    out_size_r   <= out_size_nxt;
    out_status_r <= out_status_nxt;
    out_ff_r     <= out_ff_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_grant_address  = out_addr_r;
  assign out_granted_size   = out_size_r;
  assign out_status         = out_status_r;
  assign out_from_free_list = out_ff_r;

  // a result only follows the finishing step
  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FINISH))
    else $error("result without finishing step");

  // an accepted request always starts the scan
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_SCAN))
    else $error("accepted request did not start scan");

  // failed requests carry no grant
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != fpba_pkg::ST_OK)) |->
      ((out_grant_address == '0) && (out_granted_size == '0) && !out_from_free_list))
    else $error("failed request carries a grant");

endmodule

// ===== rtl/core/fpba_ram.sv =====
// generic single-write, single-read ram with registered read data
module fpba_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fpba_pick.sv =====
// scan unit: compares one entry of each table per cycle against the request
module fpba_pick #(
  parameter int ADDR_BITS = fpba_pkg::ADDR_BITS_DEF
) (
  input  logic                          op,
  input  logic [fpba_pkg::POLICY_W-1:0] policy,
  input  logic [fpba_pkg::FIELD_W-1:0]  req_size,
  input  logic [ADDR_BITS-1:0]          block_addr,
  input  logic                          free_in,
  input  logic                          free_v,
  input  logic [fpba_pkg::FIELD_W-1:0]  free_size,
  input  logic                          used_in,
  input  logic                          used_v,
  input  logic [ADDR_BITS-1:0]          used_addr,
  input  logic                          pick_found,
  input  logic [fpba_pkg::FIELD_W-1:0]  best_size,
  input  logic                          spare_found,
  input  logic                          slot_found,
  output fpba_pkg::pick_t               take
);

  logic fits;
  logic smaller;
  logic larger;
  logic better;

  // size compares for the fit decision
  assign fits    = !(free_size < req_size);
  assign smaller = free_size < best_size;
  assign larger  = free_size > best_size;

  // replace the candidate only on a strict improvement, so ties keep the lower slot
  assign better = !pick_found
               || ((policy == fpba_pkg::POL_BEST) && smaller)
               || ((policy == fpba_pkg::POL_WORST) && larger);

  always_comb begin
    take.fit_take   = (op == fpba_pkg::OP_ALLOC) && free_in && free_v && fits && better;
    take.match_take = (op == fpba_pkg::OP_FREE) && used_in && used_v
                      && (used_addr == block_addr) && !pick_found;
    take.spare_take = free_in && !free_v && !spare_found;
    take.slot_take  = used_in && !used_v && !slot_found;
  end

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the fit-policy block allocator
`timescale 1ns / 1ps

module tb_top;
  import fpba_pkg::*;

  localparam int FREE_SLOTS   = FREE_ENTRIES_DEF;
  localparam int USED_SLOTS   = USED_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 24;
  localparam int SEG_ITEMS    = 120;

  // spare policy code, expected to act as first fit
  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t              addr;
    field_t              size;
    logic [STATUS_W-1:0] status;
    logic                from_free;
  } grant_t;

  // allocator tables mirror plus the queue of grants still to arrive
  class allocator_checker;
    logic [POLICY_W-1:0] policy;
    field_t heap_base, heap_limit, heap_top;
    field_t free_addr [FREE_SLOTS];
    field_t free_size [FREE_SLOTS];
    bit     free_valid[FREE_SLOTS];
    field_t used_addr [USED_SLOTS];
    field_t used_size [USED_SLOTS];
    bit     used_valid[USED_SLOTS];
    grant_t expected_grants[$];
    int     mismatch_count;

    function new();
      policy     = POL_FIRST;
      heap_base  = '0;
      heap_limit = HEAP_LIMIT_RST;
      heap_top   = '0;
      foreach (free_valid[i]) free_valid[i] = 1'b0;
      foreach (used_valid[i]) used_valid[i] = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, field_t data);
      case (idx)
        CFG_FIT_POLICY: policy = data[POLICY_W-1:0];
        CFG_HEAP_BASE: begin
          heap_base = data;
          heap_top  = data;
        end
        CFG_HEAP_LIMIT: heap_limit = data;
        default: ;
      endcase
    endfunction

    function int first_empty_free();
      for (int i = 0; i < FREE_SLOTS; i++)
        if (!free_valid[i]) return i;
      return -1;
    endfunction

    function int first_empty_used();
      for (int i = 0; i < USED_SLOTS; i++)
        if (!used_valid[i]) return i;
      return -1;
    endfunction

    function grant_t predict_alloc(field_t req);
      grant_t res;
      int slot, pick, spare;
      field_t base, size, grant;
      logic [FIELD_W:0] new_top;
      res = '0;
      res.status = ST_NO_SPACE;
      slot = first_empty_used();
      if (req == '0 || slot < 0) return res;
      // search the free table; ties keep the lowest slot
      pick = -1;
      for (int i = 0; i < FREE_SLOTS; i++) begin
        if (!free_valid[i] || free_size[i] < req) continue;
        if (pick < 0) begin
          pick = i;
          if (policy != POL_BEST && policy != POL_WORST) break;
        end else if (policy == POL_BEST && free_size[i] < free_size[pick]) begin
          pick = i;
        end else if (policy == POL_WORST && free_size[i] > free_size[pick]) begin
          pick = i;
        end
      end
      if (pick >= 0) begin
        base  = free_addr[pick];
        size  = free_size[pick];
        grant = size;
        // split a larger block unless the free table has no room for the remainder
        spare = first_empty_free();
        if (size > req && spare >= 0) begin
          grant             = req;
          free_addr[spare]  = base + req;
          free_size[spare]  = size - req;
          free_valid[spare] = 1'b1;
        end
        free_valid[pick] = 1'b0;
        used_addr[slot]  = base;
        used_size[slot]  = grant;
        used_valid[slot] = 1'b1;
        res = '{base, grant, ST_OK, 1'b1};
        return res;
      end
      // nothing fits, take from the heap top
      new_top = {1'b0, heap_top} + req;
      if (new_top > {1'b0, heap_limit}) return res;
      used_addr[slot]  = heap_top;
      used_size[slot]  = req;
      used_valid[slot] = 1'b1;
      res = '{heap_top, req, ST_OK, 1'b0};
      heap_top = new_top[FIELD_W-1:0];
      return res;
    endfunction

    function grant_t predict_free(field_t addr);
      grant_t res;
      int hit, spare;
      res = '0;
      hit = -1;
      for (int i = 0; i < USED_SLOTS; i++)
        if (used_valid[i] && used_addr[i] == addr) begin
          hit = i;
          break;
        end
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
        return res;
      end
      spare = first_empty_free();
      if (spare < 0) begin
        res.status = ST_NO_SPACE;
        return res;
      end
      free_addr[spare]  = used_addr[hit];
      free_size[spare]  = used_size[hit];
      free_valid[spare] = 1'b1;
      used_valid[hit]   = 1'b0;
      res.status = ST_OK;
      return res;
    endfunction

    // accepted request transfer
    function void note_request(logic op, field_t req, field_t addr);
      if (op == OP_FREE) expected_grants.push_back(predict_free(addr));
      else expected_grants.push_back(predict_alloc(req));
    endfunction

    function void compare_field(string name, field_t want, field_t got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    // result transfer against the oldest pending grant
    function void check_result(field_t addr, field_t size, logic [STATUS_W-1:0] status,
                               logic from_free);
      grant_t want;
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual addr %h size %h status %0d",
                 $time, addr, size, status);
        mismatch_count++;
        return;
      end
      want = expected_grants.pop_front();
      compare_field("grant_address", want.addr, addr);
      compare_field("granted_size", want.size, size);
      compare_field("status", field_t'(want.status), field_t'(status));
      compare_field("from_free_list", field_t'(want.from_free), field_t'(from_free));
    endfunction

    function field_t random_used_addr(output bit hit);
      int slots[$];
      foreach (used_valid[i]) if (used_valid[i]) slots.push_back(i);
      hit = (slots.size() != 0);
      if (!hit) return '0;
      return used_addr[slots[$urandom_range(0, slots.size() - 1)]];
    endfunction

    function field_t random_free_size(output bit hit);
      int slots[$];
      foreach (free_valid[i]) if (free_valid[i]) slots.push_back(i);
      hit = (slots.size() != 0);
      if (!hit) return '0;
      return free_size[slots[$urandom_range(0, slots.size() - 1)]];
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 in_op = OP_ALLOC;
  field_t               in_req_size = '0;
  field_t               in_block_address = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIT_POLICY;
  field_t               cfg_data = '0;
  logic                 busy;
  logic                 out_valid;
  field_t               out_grant_address;
  field_t               out_granted_size;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_from_free_list;

  allocator_checker model = new();
  int idle_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fit_policy_block_allocator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_req_size        (in_req_size),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_grant_address  (out_grant_address),
    .out_granted_size   (out_granted_size),
    .out_status         (out_status),
    .out_from_free_list (out_from_free_list),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      model.check_result(out_grant_address, out_granted_size, out_status,
                         out_from_free_list);
  end

  // one request transfer, with an optional random gap in front
  task automatic request(input logic op, input field_t req, input field_t addr);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start            <= 1'b1;
    in_op            <= op;
    in_req_size      <= req;
    in_block_address <= addr;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    model.note_request(op, req, addr);
  endtask

  // drain all pending grants, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (model.expected_grants.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input field_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    model.write_reg(idx, data);
  endtask

  task automatic configure(input logic [POLICY_W-1:0] pol, input field_t base,
                           input field_t limit);
    settle();
    write_reg(CFG_FIT_POLICY, field_t'(pol));
    write_reg(CFG_HEAP_BASE, base);
    write_reg(CFG_HEAP_LIMIT, limit);
    cfg_we <= 1'b0;
  endtask

  // mostly frees of live blocks and allocs of small or exactly fitting sizes
  task automatic random_request(input int alloc_pct);
    field_t req, addr, pick;
    bit hit;
    int roll;
    roll = $urandom_range(0, 99);
    req  = field_t'($urandom());
    addr = field_t'($urandom());
    if ($urandom_range(0, 99) < alloc_pct) begin
      if (roll < 60) req = field_t'($urandom_range(1, 48));
      else if (roll < 75) req = field_t'($urandom_range(1, 4096));
      else if (roll < 87) begin
        pick = model.random_free_size(hit);
        req  = hit ? pick : field_t'($urandom_range(1, 48));
      end else if (roll < 97) req = field_t'($urandom());
      else req = '0;
      request(OP_ALLOC, req, addr);
    end else begin
      if (roll < 85) begin
        pick = model.random_used_addr(hit);
        if (hit) addr = pick;
      end
      request(OP_FREE, req, addr);
    end
  endtask

  task automatic run_segment(input logic [POLICY_W-1:0] pol, input field_t base,
                             input field_t limit, input int alloc_pct);
    configure(pol, base, limit);
    repeat (SEG_ITEMS) random_request(alloc_pct);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, heap extremes, split and exact fit
    request(OP_FREE, 20'hFFFFF, 20'h12345);
    request(OP_ALLOC, 20'h00000, 20'hFFFFF);
    request(OP_ALLOC, 20'hFFFFF, 20'h00000);
    request(OP_ALLOC, 20'h00001, 20'h00000);
    request(OP_FREE, 20'h00000, 20'h00000);
    request(OP_ALLOC, 20'h00010, 20'hABCDE);
    request(OP_ALLOC, 20'hFFFEF, 20'h54321);
    request(OP_FREE, 20'h00000, 20'h00010);
    request(OP_FREE, 20'h00000, 20'h00010);
    request(OP_FREE, 20'h00000, 20'h00000);

    // best fit takes the small block, then an exact fit
    configure(POL_BEST, 20'h80000, 20'h80100);
    request(OP_ALLOC, 20'h00008, 20'h00000);
    request(OP_ALLOC, 20'h00008, 20'h00000);

    // worst fit takes the large block
    configure(POL_WORST, 20'h80000, 20'h80100);
    request(OP_ALLOC, 20'h00100, 20'h00000);
    request(OP_ALLOC, 20'h00200, 20'h00000);

    // spare policy code, then fill the allocated table and overflow it
    configure(POL_UNUSED, 20'h80000, 20'h80100);
    request(OP_ALLOC, 20'h00004, 20'h00000);
    while (model.first_empty_used() >= 0) request(OP_ALLOC, 20'h00002, 20'h00000);
    request(OP_ALLOC, 20'h00002, 20'h00000);

    // random: sender gaps in about a fifth of the requests
    idle_pct = 22;
    run_segment(POL_FIRST, 20'h00000, 20'hFFFFF, 60);
    run_segment(POL_BEST, 20'h00100, 20'h00800, 55);
    run_segment(POL_WORST, 20'h00100, 20'h00800, 45);

    // random: sender gaps in most requests
    idle_pct = 69;
    run_segment(POL_UNUSED, 20'h7FF00, 20'h80400, 60);
    run_segment(POL_BEST, 20'hFFFFF, 20'hFFFFF, 40);
    run_segment(POL_WORST, 20'h00000, 20'h00000, 40);

    // random: back to back
    idle_pct = 0;
    run_segment(POL_FIRST, 20'h00000, 20'h01000, 70);
    run_segment(POL_BEST, 20'h40000, 20'hFFFFF, 50);
    run_segment(POL_WORST, 20'h01000, 20'h03000, 55);

    settle();
    if (model.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fpba_pkg.sv
rtl/core/fpba_ram.sv
rtl/core/fpba_pick.sv
rtl/core/fit_policy_block_allocator.sv
test/tb_top.sv
